### design/assert_macros.svh
// Assertion helpers shared by the key table and scaler design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the property holds at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that the condition is never true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### design/mkds_pkg.sv
package mkds_pkg;

   localparam int NUM_KEYS = 8;
   localparam int KEY_W = 3;
   localparam int RUN_W = 8;
   localparam int TICK_W = 17;
   localparam int PERIOD_W = 10;
   localparam int DUR_W = 27;
   localparam int CSR_DATA_W = 10;

   localparam logic [TICK_W-1:0] PRESS_LIMIT = 17'd100000;

   localparam logic [RUN_W-1:0] DEBOUNCE_RESET = 8'd2;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd50;

   localparam logic CSR_DEBOUNCE_COUNT = 1'b0;
   localparam logic CSR_SCAN_PERIOD = 1'b1;

   localparam logic [1:0] EV_NONE = 2'd0;
   localparam logic [1:0] EV_PRESSED = 2'd1;
   localparam logic [1:0] EV_HELD = 2'd2;
   localparam logic [1:0] EV_RELEASED = 2'd3;

   typedef struct packed {
      logic [KEY_W-1:0] key_index;
      logic key_level;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0] event_key;
      logic [1:0] event_kind;
      logic [DUR_W-1:0] duration_ms;
      logic was_pressed;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0] event_key;
      logic [1:0] event_kind;
      logic [TICK_W-1:0] ticks;
      logic was_pressed;
   } mid_type;

endpackage

### design/mkds_key_table.sv
`include "assert_macros.svh"

module mkds_key_table import mkds_pkg::*; (
   input logic clock,
   input logic reset,
   input logic in_valid,
   input req_type in_item,
   output logic in_ready,
   input logic [RUN_W-1:0] debounce_count,
   output logic mid_valid,
   output mid_type mid_item,
   input logic mid_ready
);

   logic phase_ff [NUM_KEYS];
   logic [RUN_W-1:0] run_ff [NUM_KEYS];
   logic [TICK_W-1:0] ticks_ff [NUM_KEYS];

   logic mid_valid_ff;
   logic mid_valid_in;
   mid_type mid_ff;
   mid_type mid_in;

   logic cur_phase;
   logic [RUN_W-1:0] cur_run;
   logic [TICK_W-1:0] cur_ticks;
   logic [RUN_W-1:0] run_inc;
   logic run_hit;
   logic [TICK_W:0] ticks_sum;
   logic [TICK_W-1:0] ticks_sat;
   logic nxt_phase;
   logic [RUN_W-1:0] nxt_run;
   logic [TICK_W-1:0] nxt_ticks;
   logic load;

   assign in_ready = !mid_valid_ff || mid_ready;
   assign load = in_valid && in_ready;

   assign cur_phase = phase_ff[in_item.key_index];
   assign cur_run = run_ff[in_item.key_index];
   assign cur_ticks = ticks_ff[in_item.key_index];
   assign run_inc = cur_run + 1'b1;
   assign run_hit = run_inc >= debounce_count;
   assign ticks_sum = {1'b0, cur_ticks} + 1'b1;
   assign ticks_sat = (ticks_sum >= {1'b0, PRESS_LIMIT}) ? PRESS_LIMIT : ticks_sum[TICK_W-1:0];

   always_comb begin
      nxt_phase = cur_phase;
      nxt_run = cur_run;
      nxt_ticks = cur_ticks;
      mid_in.event_key = in_item.key_index;
      mid_in.event_kind = EV_NONE;
      mid_in.ticks = '0;
      mid_in.was_pressed = cur_phase;
      if (!cur_phase) begin
         if (in_item.key_level) begin
            if (run_hit) begin
               nxt_run = '0;
               nxt_phase = 1'b1;
               mid_in.event_kind = EV_PRESSED;
            end else begin
               nxt_run = run_inc;
            end
         end else begin
            nxt_run = '0;
         end
      end else begin
         nxt_ticks = ticks_sat;
         mid_in.ticks = ticks_sat;
         mid_in.event_kind = EV_HELD;
         if (!in_item.key_level) begin
            if (run_hit) begin
               nxt_run = '0;
               nxt_ticks = '0;
               nxt_phase = 1'b0;
               mid_in.event_kind = EV_RELEASED;
            end else begin
               nxt_run = run_inc;
            end
         end else begin
            nxt_run = '0;
         end
      end
   end

   always_comb begin
      mid_valid_in = mid_valid_ff;
      if (load) begin
         mid_valid_in = 1'b1;
      end else if (mid_ready) begin
         mid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_KEYS; k++) begin
            phase_ff[k] <= 1'b0;
            run_ff[k] <= '0;
            ticks_ff[k] <= '0;
         end
      end else if (load) begin
         phase_ff[in_item.key_index] <= nxt_phase;
         run_ff[in_item.key_index] <= nxt_run;
         ticks_ff[in_item.key_index] <= nxt_ticks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mid_ff <= mid_in;
      end
   end

   assign mid_valid = mid_valid_ff;
   assign mid_item = mid_ff;

   `ASSERT_PROP(released_key_has_no_ticks, clock, reset, in_valid && !phase_ff[in_item.key_index] |-> ticks_ff[in_item.key_index] == '0, "Released key holds a nonzero press count.")
   `ASSERT_NEVER(ticks_above_limit, clock, reset, in_valid && (ticks_ff[in_item.key_index] > PRESS_LIMIT), "Press count exceeds its saturation limit.")
   `ASSERT_PROP(press_sets_phase, clock, reset, load && mid_in.event_kind == EV_PRESSED |=> phase_ff[mid_ff.event_key], "Press transaction did not move the key to the pressed phase.")

endmodule

### design/mkds_scaler.sv
`include "assert_macros.svh"

module mkds_scaler import mkds_pkg::*; (
   input logic clock,
   input logic reset,
   input logic mid_valid,
   input mid_type mid_item,
   output logic mid_ready,
   input logic [PERIOD_W-1:0] scan_period_ms,
   output logic rsp_valid,
   output rsp_type rsp_item,
   input logic rsp_ready
);

   logic rsp_valid_ff;
   logic rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic [DUR_W-1:0] product;
   logic load;

   assign mid_ready = !rsp_valid_ff || rsp_ready;
   assign load = mid_valid && mid_ready;

   assign product = DUR_W'(mid_item.ticks) * DUR_W'(scan_period_ms);

   always_comb begin
      rsp_in.event_key = mid_item.event_key;
      rsp_in.event_kind = mid_item.event_kind;
      rsp_in.duration_ms = product;
      rsp_in.was_pressed = mid_item.was_pressed;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

   `ASSERT_PROP(no_duration_without_press, clock, reset, rsp_valid_ff && (rsp_ff.event_kind == EV_NONE || rsp_ff.event_kind == EV_PRESSED) |-> rsp_ff.duration_ms == '0, "Duration reported for a transaction without a held key.")

endmodule

### design/multi_key_debounce_scanner.sv
// A request passes through the input, key table and scaler registers before its
// result is valid. Throughput: one request per cycle while rsp_ready holds;
// every stage of input register, key table update and duration multiply is
// registered with its own valid bit. Reset clears the key table, all valid bits
// and restores both configuration registers to their defaults.
module multi_key_debounce_scanner import mkds_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input req_type req_payload,
   output logic rsp_valid,
   input logic rsp_ready,
   output rsp_type rsp_payload,
   input logic csr_write_enable,
   input logic csr_index,
   input logic [CSR_DATA_W-1:0] csr_write_data
);

   logic req_valid_ff;
   logic req_valid_in;
   req_type req_ff;
   logic [RUN_W-1:0] debounce_count_ff;
   logic [PERIOD_W-1:0] scan_period_ff;
   logic table_ready;
   logic mid_valid;
   logic mid_ready;
   mid_type mid_item;

   assign req_ready = !req_valid_ff || table_ready;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_valid && req_ready) begin
         req_valid_in = 1'b1;
      end else if (table_ready) begin
         req_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_count_ff <= DEBOUNCE_RESET;
         scan_period_ff <= PERIOD_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DEBOUNCE_COUNT: begin
               debounce_count_ff <= csr_write_data[RUN_W-1:0];
            end
            CSR_SCAN_PERIOD: begin
               scan_period_ff <= csr_write_data[PERIOD_W-1:0];
            end
            default: begin
               scan_period_ff <= scan_period_ff;
            end
         endcase
      end
   end

   mkds_key_table u_key_table (
      .clock(clock),
      .reset(reset),
      .in_valid(req_valid_ff),
      .in_item(req_ff),
      .in_ready(table_ready),
      .debounce_count(debounce_count_ff),
      .mid_valid(mid_valid),
      .mid_item(mid_item),
      .mid_ready(mid_ready)
   );

   mkds_scaler u_scaler (
      .clock(clock),
      .reset(reset),
      .mid_valid(mid_valid),
      .mid_item(mid_item),
      .mid_ready(mid_ready),
      .scan_period_ms(scan_period_ff),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_payload),
      .rsp_ready(rsp_ready)
   );

endmodule

### test/key_event_checker.sv
`timescale 1ns / 100ps

module key_event_checker import mkds_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input req_type req_payload,
   input logic rsp_valid,
   input logic rsp_ready,
   input rsp_type rsp_payload,
   input logic csr_write_enable,
   input logic csr_index,
   input logic [CSR_DATA_W-1:0] csr_write_data,
   output int error_count,
   output int pending_count
);

   logic key_pressed [NUM_KEYS];
   logic [RUN_W-1:0] run_len [NUM_KEYS];
   logic [TICK_W-1:0] hold_ticks [NUM_KEYS];
   logic [RUN_W-1:0] debounce_cfg;
   logic [PERIOD_W-1:0] period_cfg;
   rsp_type expected_events [$];
   int mismatches = 0;

   initial begin
      error_count = 0;
      pending_count = 0;
   end

   function automatic rsp_type predict_key_event(input req_type sample);
      rsp_type ev;
      logic [KEY_W-1:0] k;
      logic [RUN_W-1:0] run_next;
      logic [TICK_W-1:0] ticks_next;
      k = sample.key_index;
      ev.event_key = k;
      ev.event_kind = EV_NONE;
      ev.duration_ms = '0;
      ev.was_pressed = key_pressed[k];
      run_next = run_len[k] + 8'd1;
      if (!key_pressed[k]) begin
         if (sample.key_level) begin
            if (run_next >= debounce_cfg) begin
               run_len[k] = '0;
               key_pressed[k] = 1'b1;
               ev.event_kind = EV_PRESSED;
            end else begin
               run_len[k] = run_next;
            end
         end else begin
            run_len[k] = '0;
         end
      end else begin
         if (hold_ticks[k] >= PRESS_LIMIT - 17'd1) begin
            ticks_next = PRESS_LIMIT;
         end else begin
            ticks_next = hold_ticks[k] + 17'd1;
         end
         hold_ticks[k] = ticks_next;
         ev.event_kind = EV_HELD;
         if (!sample.key_level) begin
            if (run_next >= debounce_cfg) begin
               run_len[k] = '0;
               ev.event_kind = EV_RELEASED;
            end else begin
               run_len[k] = run_next;
            end
         end else begin
            run_len[k] = '0;
         end
         ev.duration_ms = DUR_W'(ticks_next) * DUR_W'(period_cfg);
         if (ev.event_kind == EV_RELEASED) begin
            hold_ticks[k] = '0;
            key_pressed[k] = 1'b0;
         end
      end
      return ev;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < NUM_KEYS; i++) begin
            key_pressed[i] = 1'b0;
            run_len[i] = '0;
            hold_ticks[i] = '0;
         end
         debounce_cfg = DEBOUNCE_RESET;
         period_cfg = PERIOD_RESET;
         expected_events.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               $error("Unexpected rsp transaction: key %0d kind %0d duration %0d",
                      rsp_payload.event_key, rsp_payload.event_kind,
                      rsp_payload.duration_ms);
               mismatches++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_payload.event_key !== want.event_key) begin
                  $error("event_key: expected %0d, actual %0d",
                         want.event_key, rsp_payload.event_key);
                  mismatches++;
               end
               if (rsp_payload.event_kind !== want.event_kind) begin
                  $error("event_kind: expected %0d, actual %0d",
                         want.event_kind, rsp_payload.event_kind);
                  mismatches++;
               end
               if (rsp_payload.duration_ms !== want.duration_ms) begin
                  $error("duration_ms: expected %0d, actual %0d",
                         want.duration_ms, rsp_payload.duration_ms);
                  mismatches++;
               end
               if (rsp_payload.was_pressed !== want.was_pressed) begin
                  $error("was_pressed: expected %0d, actual %0d",
                         want.was_pressed, rsp_payload.was_pressed);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_events.push_back(predict_key_event(req_payload));
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_DEBOUNCE_COUNT: debounce_cfg = csr_write_data[RUN_W-1:0];
               CSR_SCAN_PERIOD: period_cfg = csr_write_data[PERIOD_W-1:0];
               default: ;
            endcase
         end
      end
      pending_count <= expected_events.size();
      error_count <= mismatches;
   end

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;
   import mkds_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic csr_write_enable = 1'b0;
   logic csr_index = CSR_DEBOUNCE_COUNT;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count;
   int pending_count;

   multi_key_debounce_scanner DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   key_event_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .error_count(error_count),
      .pending_count(pending_count)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic send_sample(input logic [KEY_W-1:0] key, input logic level);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{key_index: key, key_level: level};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_run(input logic [KEY_W-1:0] key, input logic level, input int count);
      for (int i = 0; i < count; i++) begin
         send_sample(key, level);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Bursts of one level on one key, so presses and releases get through the
   // debounce, with flipped samples and stray samples on random keys mixed in.
   task automatic random_bursts(input int total, input int burst_max);
      int sent;
      int burst;
      logic [KEY_W-1:0] key;
      logic level;
      sent = 0;
      while (sent < total) begin
         key = KEY_W'($urandom_range(0, NUM_KEYS - 1));
         level = 1'($urandom_range(0, 1));
         burst = $urandom_range(1, burst_max);
         for (int i = 0; i < burst && sent < total; i++) begin
            if ($urandom_range(0, 7) == 0) begin
               send_sample(KEY_W'($urandom_range(0, NUM_KEYS - 1)),
                           1'($urandom_range(0, 1)));
            end else if ($urandom_range(0, 9) == 0) begin
               send_sample(key, !level);
            end else begin
               send_sample(key, level);
            end
            sent++;
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 28;
      recv_idle_pct = 79;
      send_sample(3'd0, 1'b1);
      send_sample(3'd0, 1'b1);
      send_sample(3'd0, 1'b1);
      send_sample(3'd0, 1'b0);
      send_sample(3'd0, 1'b1);
      send_sample(3'd0, 1'b0);
      send_sample(3'd0, 1'b0);
      send_sample(3'd7, 1'b1);
      send_sample(3'd7, 1'b0);
      send_sample(3'd7, 1'b1);
      send_sample(3'd7, 1'b1);
      send_sample(3'd7, 1'b0);
      send_sample(3'd7, 1'b0);
      send_sample(3'd3, 1'b1);
      send_sample(3'd4, 1'b1);
      send_sample(3'd3, 1'b1);
      send_sample(3'd4, 1'b0);
      send_sample(3'd5, 1'b0);
      send_sample(3'd6, 1'b1);
      send_sample(3'd1, 1'b1);
      send_sample(3'd2, 1'b0);
      random_bursts(120, 6);
      wait_drained();

      send_idle_pct = 79;
      recv_idle_pct = 28;
      write_csr(CSR_DEBOUNCE_COUNT, 10'd0);
      write_csr(CSR_SCAN_PERIOD, 10'd1000);
      send_sample(3'd2, 1'b1);
      send_sample(3'd2, 1'b1);
      send_sample(3'd2, 1'b0);
      random_bursts(50, 6);
      wait_drained();
      random_bursts(50, 6);
      send_sample(3'd1, 1'b0);
      wait_drained();
      write_csr(CSR_DEBOUNCE_COUNT, 10'd200);
      send_run(3'd1, 1'b1, 100);
      wait_drained();
      write_csr(CSR_DEBOUNCE_COUNT, 10'd50);
      send_sample(3'd1, 1'b1);
      send_sample(3'd1, 1'b1);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(CSR_DEBOUNCE_COUNT, 10'd255);
      write_csr(CSR_SCAN_PERIOD, 10'd1);
      send_sample(3'd5, 1'b0);
      send_run(3'd5, 1'b1, 255);
      send_run(3'd5, 1'b1, 3);
      send_run(3'd5, 1'b0, 255);
      wait_drained();
      write_csr(CSR_DEBOUNCE_COUNT, 10'd1);
      write_csr(CSR_SCAN_PERIOD, 10'd1000);
      send_sample(3'd6, 1'b0);
      send_sample(3'd6, 1'b1);
      send_run(3'd6, 1'b1, 40);
      send_sample(3'd6, 1'b0);
      wait_drained();
      write_csr(CSR_DEBOUNCE_COUNT, 10'd3);
      write_csr(CSR_SCAN_PERIOD, 10'd777);
      random_bursts(50, 10);

      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

### sim.f
+incdir+design
design/mkds_pkg.sv
design/mkds_key_table.sv
design/mkds_scaler.sv
design/multi_key_debounce_scanner.sv
test/key_event_checker.sv
test/tb.sv
